// ===== rtl/core/eluga_pkg.sv =====
// ----------------------------------------------------------------------------
// ELU gradient accumulate: shared package
// Fixed-point formats, exponential constants, the reciprocal table used by the
// Horner steps and the sideband record that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package eluga_pkg;

	// Value format: signed Q4.12 in 16 bits.
	localparam int VALUE_WIDTH = 16;
	localparam int FRAC_BITS   = 12;

	// Exponential internals are unsigned Q1.30.
	localparam int Q_BITS = 30;
	localparam logic [Q_BITS:0]   Q30_ONE   = 31'h4000_0000;
	localparam logic [Q_BITS:0]   LOG2E_Q30 = 31'd1549082005;
	localparam logic [Q_BITS-1:0] LN2_Q30   = 30'd744261118;

	// Shift of the reciprocal multiply that replaces the divide by k.
	localparam int RECIP_SHIFT = 33;

	// Number of Horner steps (terms up to v^6).
	localparam int HORNER_TERMS = 6;

	// ceil(2^33 / k); exact quotient for 31-bit dividends below 2^30.
	function automatic logic [33:0] recip_q33(input logic [2:0] k);
		logic [33:0] m;
		case (k)
			3'd1:    m = 34'h2_0000_0000;
			3'd2:    m = 34'h1_0000_0000;
			3'd3:    m = 34'd2863311531;
			3'd4:    m = 34'h0_8000_0000;
			3'd5:    m = 34'd1717986919;
			3'd6:    m = 34'd1431655766;
			default: m = 34'd0;
		endcase
		return m;
	endfunction

	// Fields that ride along with the exponential computation.
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] grad;
		logic signed [VALUE_WIDTH-1:0] acc;
		logic                          last;
		logic                          act_pos;
		logic [5:0]                    n;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/core/elu_gradient_accumulate_top.sv =====
// ----------------------------------------------------------------------------
// ELU gradient accumulate: top level
// Element-wise ELU backward step with a saturating accumulate, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis: grad, activation and accumulator (Q4.12),
//   with tlast marking the final element of a vector. Each accepted word gives
//   exactly one output word on m_axis: the new accumulator in tdata, the
//   saturation flag in tuser, and tlast copied from the input.
//   The alpha register (unsigned Q4.12, 1.0 after reset) is written through
//   cfg_valid/cfg_data, always ready. The user must write it only while no
//   word is in flight; the block itself does not enforce this. The pipe has
//   18 register stages: two for the log2(e) and ln(2) scaling, twelve for six
//   Horner steps of exp (a multiply stage and a reciprocal-divide stage each),
//   then the exponent shift, the alpha multiply, the gradient multiply and the
//   add with saturation. Throughput is one word per cycle while the receiver
//   keeps up. Every stage has a valid bit and takes a new word when it is
//   empty or its word moves on, so bubbles are squeezed out and input is still
//   taken while the output word waits. When the receiver stalls, words stop in
//   place and none is lost or repeated.
//   Reset clears all valid bits and restores alpha.
// ----------------------------------------------------------------------------
`default_nettype none

module elu_gradient_accumulate_top
	import eluga_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: alpha.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // grad_value, activation_value, accum_value
	input  wire logic        s_axis_tlast,  // last_in
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // accum_out
	output logic             m_axis_tuser,  // saturated
	output logic             m_axis_tlast   // last_out
);

	localparam int VW = VALUE_WIDTH;

	logic [VW-1:0] alpha_q;

	logic signed [VW-1:0] in_grad;
	logic signed [VW-1:0] in_act;
	logic signed [VW-1:0] in_acc;
	logic signed [VW:0]   act_ext;
	logic [VW:0]          ax;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic [47:0] ymul_s1;
	side_t       side_s1;
	logic [59:0] vmul_s2;
	side_t       side_s2;
	logic [Q_BITS:0] e_s3;
	side_t       side_s3;
	logic [46:0] ae_s4;
	side_t       side_s4;
	logic [33:0] prod_s5;
	side_t       side_s5;
	logic [VW-1:0] sum_s6;
	logic        sat_s6;
	logic        last_s6;

	logic [35:0]       y;
	logic [Q_BITS-1:0] f;
	logic [Q_BITS:0]   e_next;
	logic [47:0]       ae_rnd;
	logic [16:0]       scale;
	logic [16:0]       mag;
	logic [34:0]       prod_rnd;
	logic [22:0]       r;
	logic signed [24:0] term;
	logic signed [24:0] sum;
	logic signed [24:0] max_v;
	logic signed [24:0] min_v;

	logic              step_valid [0:HORNER_TERMS];
	logic              step_ready [0:HORNER_TERMS];
	logic [Q_BITS-1:0] step_v     [0:HORNER_TERMS];
	logic [Q_BITS:0]   step_t     [0:HORNER_TERMS];
	side_t             step_side  [0:HORNER_TERMS];

	// Alpha register; configuration is always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd4096;
		end else if (cfg_valid) begin
			alpha_q <= cfg_data;
		end
	end

	// Ready chain: a stage takes a word when it is empty or its word moves on.
	assign rdy_s6        = !vld_s6 || m_axis_tready;
	assign rdy_s5        = !vld_s5 || rdy_s6;
	assign rdy_s4        = !vld_s4 || rdy_s5;
	assign rdy_s3        = !vld_s3 || rdy_s4;
	assign rdy_s2        = !vld_s2 || step_ready[0];
	assign rdy_s1        = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	// Valid bits of the stages owned here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= step_valid[HORNER_TERMS];
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
			if (rdy_s6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	// Stage 1: unpack and scale -x by log2(e).
	assign in_grad = s_axis_tdata[15:0];
	assign in_act  = s_axis_tdata[31:16];
	assign in_acc  = s_axis_tdata[47:32];
	assign act_ext = {in_act[VW-1], in_act};
	assign ax      = (VW+1)'(-act_ext);

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			ymul_s1         <= 48'(ax) * 48'(LOG2E_Q30);
			side_s1.grad    <= in_grad;
			side_s1.acc     <= in_acc;
			side_s1.last    <= s_axis_tlast;
			side_s1.act_pos <= (in_act > 0);
			side_s1.n       <= '0;
		end
	end

	// Stage 2: split into integer and fraction, fraction times ln(2).
	assign y = ymul_s1[47:FRAC_BITS];
	assign f = y[Q_BITS-1:0];

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			vmul_s2         <= 60'(f) * 60'(LN2_Q30);
			side_s2.grad    <= side_s1.grad;
			side_s2.acc     <= side_s1.acc;
			side_s2.last    <= side_s1.last;
			side_s2.act_pos <= side_s1.act_pos;
			side_s2.n       <= y[35:Q_BITS];
		end
	end

	// Horner evaluation of exp(-v), k = 6 down to 1.
	assign step_valid[0] = vld_s2;
	assign step_v[0]     = vmul_s2[59:Q_BITS];
	assign step_t[0]     = Q30_ONE;
	assign step_side[0]  = side_s2;
	assign step_ready[HORNER_TERMS] = rdy_s3;

	for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_step
		eluga_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (3'(HORNER_TERMS - i)),
			.in_valid  (step_valid[i]),
			.in_ready  (step_ready[i]),
			.v_in      (step_v[i]),
			.t_in      (step_t[i]),
			.side_in   (step_side[i]),
			.out_valid (step_valid[i+1]),
			.out_ready (step_ready[i+1]),
			.v_out     (step_v[i+1]),
			.t_out     (step_t[i+1]),
			.side_out  (step_side[i+1])
		);
	end

	// Stage 3: apply the power of two; far underflow gives zero.
	assign e_next = (step_side[HORNER_TERMS].n > 6'd30) ? '0
		: (step_t[HORNER_TERMS] >> step_side[HORNER_TERMS].n);

	always_ff @(posedge clk) begin
		if (rdy_s3 && step_valid[HORNER_TERMS]) begin
			e_s3    <= e_next;
			side_s3 <= step_side[HORNER_TERMS];
		end
	end

	// Stage 4: alpha times exp.
	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			ae_s4   <= 47'(alpha_q) * 47'(e_s3);
			side_s4 <= side_s3;
		end
	end

	// Stage 5: round the scale to Q4.12 and multiply by |grad|.
	assign ae_rnd = 48'(ae_s4) + 48'(Q30_ONE >> 1);
	assign scale  = ae_rnd[46:Q_BITS];
	assign mag    = side_s4.grad[VW-1] ? (VW+1)'(-{side_s4.grad[VW-1], side_s4.grad})
		: (VW+1)'(side_s4.grad);

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			prod_s5 <= 34'(mag) * 34'(scale);
			side_s5 <= side_s4;
		end
	end

	// Stage 6: round the product, pick the branch, add and saturate.
	assign prod_rnd = 35'(prod_s5) + 35'(1 << (FRAC_BITS - 1));
	assign r        = prod_rnd[34:FRAC_BITS];
	assign max_v    = 25'sd32767;
	assign min_v    = -25'sd32768;

	always_comb begin
		if (side_s5.act_pos) begin
			term = 25'(side_s5.grad);
		end else if (side_s5.grad[VW-1]) begin
			term = -$signed({2'b00, r});
		end else begin
			term = $signed({2'b00, r});
		end
		sum = 25'(side_s5.acc) + term;
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			last_s6 <= side_s5.last;
			if (sum > max_v) begin
				sum_s6 <= max_v[VW-1:0];
				sat_s6 <= 1'b1;
			end else if (sum < min_v) begin
				sum_s6 <= min_v[VW-1:0];
				sat_s6 <= 1'b1;
			end else begin
				sum_s6 <= sum[VW-1:0];
				sat_s6 <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = vld_s6;
	assign m_axis_tdata  = sum_s6;
	assign m_axis_tuser  = sat_s6;
	assign m_axis_tlast  = last_s6;

endmodule

`default_nettype wire

// ===== rtl/core/eluga_horner_step.sv =====
// ----------------------------------------------------------------------------
// ELU gradient accumulate: one Horner step of exp(-v)
// Two register stages: t' = one - floor(v*t / (k * 2^30)), with the divide by
// the small constant k done by a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module eluga_horner_step
	import eluga_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [2:0]        divisor,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [Q_BITS-1:0] v_in,
	input  wire logic [Q_BITS:0]   t_in,
	input  wire side_t             side_in,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [Q_BITS-1:0]      v_out,
	output logic [Q_BITS:0]        t_out,
	output side_t                  side_out
);

	logic                  vld_s1;
	logic                  vld_s2;
	logic                  rdy_s1;
	logic                  rdy_s2;
	logic [2*Q_BITS:0]     prod_s1;
	logic [Q_BITS-1:0]     v_s1;
	side_t                 side_s1;
	logic [Q_BITS-1:0]     v_s2;
	logic [Q_BITS:0]       t_s2;
	side_t                 side_s2;
	logic [Q_BITS:0]       hi;
	logic [64:0]           qmul;
	logic [Q_BITS:0]       quo;

	// A stage takes a new word when it is empty or its word moves on.
	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Quotient of the upper product bits by k.
	assign hi   = prod_s1[2*Q_BITS:Q_BITS];
	assign qmul = 65'(hi) * 65'(recip_q33(divisor));
	assign quo  = qmul[RECIP_SHIFT+Q_BITS:RECIP_SHIFT];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Stage 1: product v*t.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			prod_s1 <= (2*Q_BITS+1)'(v_in) * (2*Q_BITS+1)'(t_in);
			v_s1    <= v_in;
			side_s1 <= side_in;
		end
	end

	// Stage 2: next Horner term.
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			t_s2    <= Q30_ONE - quo;
			v_s2    <= v_s1;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_s2;
	assign v_out     = v_s2;
	assign t_out     = t_s2;
	assign side_out  = side_s2;

endmodule

`default_nettype wire

// ===== rtl/core/eluga_checker.sv =====
// ----------------------------------------------------------------------------
// ELU gradient accumulate: port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eluga_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [15:0] cfg_data,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast
);

	// A stalled output word stays and keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
	else $error("output word changed while stalled");

	// A clipped sum is always one of the two range limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 16'h7fff
		|| m_axis_tdata == 16'h8000))
	else $error("saturated word is not a range limit");

	// Input backpressure only comes from a full pipe behind a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
	else $error("input stalled without an output stall");

	// A ready receiver lets every stage move, so the input is never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
	else $error("input stalled while the receiver is ready");

endmodule

bind elu_gradient_accumulate_top eluga_checker u_eluga_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// ELU gradient accumulate: self-checking testbench
// Drives words of gradient, activation and accumulator into the block and
// predicts each new accumulator with an independent fixed-point model of the
// ELU backward step. The model covers the exponential branch, the alpha scale
// and saturation. Output words are checked in order, field by field. Both
// stream sides idle at random, and the receiver once holds off long enough to
// back the pipeline up. The run covers several alpha settings, from 0 to the
// full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import eluga_pkg::*;

	// Receiver hold-off length in clock cycles.
	localparam int HOLD_CYCLES = 150;

	// Values that sit on the edges of the Q4.12 range or of the exp branch.
	localparam logic [VALUE_WIDTH-1:0] CORNER_VALUES [0:5] =
		'{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h1000};

	// One input word: gradient, activation, accumulator and the last flag.
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] grad;
		logic signed [VALUE_WIDTH-1:0] act;
		logic signed [VALUE_WIDTH-1:0] acc;
		logic                          last;
	} elem_t;

	// One output word: new accumulator, clip flag and the last flag.
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] accum;
		logic                   sat;
		logic                   last;
	} update_t;

	// Holds the predicted accumulator updates and compares the block against them.
	class accum_scoreboard;
		logic [VALUE_WIDTH-1:0] alpha;
		update_t                expected_q[$];
		int unsigned            errors;

		function new();
			alpha  = 16'd4096;
			errors = 0;
		endfunction

		function void set_alpha(logic [VALUE_WIDTH-1:0] value);
			alpha = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// exp(-mag) in unsigned Q30, where mag is the activation magnitude.
		// The power of two is split off, the remainder goes through a
		// sixth-order Horner series.
		function longint unsigned exp_q30(longint unsigned mag);
			longint unsigned one;
			longint unsigned scaled;
			longint unsigned whole;
			longint unsigned frac;
			longint unsigned v;
			longint unsigned t;
			longint unsigned k;
			one    = 64'd1 << 30;
			scaled = (mag * 64'd1549082005) >> FRAC_BITS;
			whole  = scaled >> 30;
			frac   = scaled & (one - 1);
			v      = (frac * 64'd744261118) >> 30;
			t      = one;
			for (k = 6; k >= 1; k--) begin
				t = one - (((v * t) / k) >> 30);
			end
			if (whole > 30) begin
				return 64'd0;
			end
			return t >> whole;
		endfunction

		// New accumulator for one word under the current alpha.
		function update_t predict(elem_t w);
			update_t         res;
			longint          g;
			longint          a;
			longint          c;
			longint          term;
			longint          total;
			longint          maxv;
			longint unsigned e;
			longint unsigned s;
			longint unsigned mag;
			longint unsigned r;
			g = w.grad;
			a = w.act;
			c = w.acc;
			maxv = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
			if (a > 0) begin
				term = g;
			end else begin
				e   = exp_q30(-a);
				s   = (alpha * e + (64'd1 << 29)) >> 30;
				mag = (g < 0) ? -g : g;
				r   = (mag * s + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				term = (g < 0) ? -longint'(r) : longint'(r);
			end
			total   = c + term;
			res.sat = 1'b0;
			if (total > maxv) begin
				total   = maxv;
				res.sat = 1'b1;
			end else if (total < -maxv - 1) begin
				total   = -maxv - 1;
				res.sat = 1'b1;
			end
			res.accum = total[VALUE_WIDTH-1:0];
			res.last  = w.last;
			return res;
		endfunction

		function void note_word(elem_t w);
			expected_q.push_back(predict(w));
		endfunction

		task flag_mismatch(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_word(update_t got);
			update_t want;
			if (expected_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected word accum=%h", got.accum));
				return;
			end
			want = expected_q.pop_front();
			if (got.accum !== want.accum) begin
				flag_mismatch($sformatf("accum got %h want %h", got.accum, want.accum));
			end
			if (got.sat !== want.sat) begin
				flag_mismatch($sformatf("saturated got %b want %b", got.sat, want.sat));
			end
			if (got.last !== want.last) begin
				flag_mismatch($sformatf("last got %b want %b", got.last, want.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // grad_value, activation_value, accum_value
	logic        s_axis_tlast;   // last_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // accum_out
	logic        m_axis_tuser;   // saturated
	logic        m_axis_tlast;   // last_out

	accum_scoreboard sb;
	int unsigned     src_idle_pct;
	int unsigned     sink_idle_pct;
	bit              hold_request;

	elu_gradient_accumulate_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watch all three handshakes at each rising edge.
	always @(posedge clk) begin : watch
		elem_t   w;
		update_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.set_alpha(cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				w.grad = s_axis_tdata[15:0];
				w.act  = s_axis_tdata[31:16];
				w.acc  = s_axis_tdata[47:32];
				w.last = s_axis_tlast;
				sb.note_word(w);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.accum = m_axis_tdata;
				got.sat   = m_axis_tuser;
				got.last  = m_axis_tlast;
				sb.check_word(got);
			end
		end
	end

	// Receiver: random back-pressure, with a long hold-off on request.
	initial begin : sink
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	function automatic elem_t make_elem(input int g, input int a, input int c, input bit l);
		elem_t w;
		w.grad = 16'(g);
		w.act  = 16'(a);
		w.acc  = 16'(c);
		w.last = l;
		return w;
	endfunction

	// Random word, weighted toward the exp branch and the saturation edges.
	function automatic elem_t random_elem();
		elem_t w;
		case ($urandom_range(0, 9))
			0, 1:    w.act = 16'($urandom_range(1, 32767));
			2, 3, 4: w.act = 16'(-int'($urandom_range(0, 12288)));
			5, 6:    w.act = 16'(-int'($urandom_range(0, 32768)));
			7:       w.act = CORNER_VALUES[$urandom_range(0, 5)];
			default: w.act = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			6, 7:    w.grad = 16'(int'($urandom_range(0, 511)) - 256);
			8, 9:    w.grad = CORNER_VALUES[$urandom_range(0, 5)];
			default: w.grad = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			5, 6:    w.acc = 16'(32767 - int'($urandom_range(0, 4096)));
			7, 8:    w.acc = 16'(-32768 + int'($urandom_range(0, 4096)));
			9:       w.acc = CORNER_VALUES[$urandom_range(0, 5)];
			default: w.acc = 16'($urandom);
		endcase
		w.last = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Offer one word, after an optional idle gap, and wait until it is taken.
	task automatic send_word(input elem_t w);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {w.acc, w.act, w.grad};
		s_axis_tlast  <= w.last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_word(random_elem());
		end
	endtask

	// Stop offering and wait until every predicted word has come out of the block.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_alpha(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Give up if the run hangs.
	initial begin
		#(2_000_000);
		$display("status: fail");
		$finish;
	end

	// Main sequence: reset, directed words, then random phases per alpha.
	initial begin
		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		src_idle_pct  = 25;
		sink_idle_pct = 25;
		hold_request  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset alpha of 1.0.
		send_word(make_elem(0, 0, 0, 0));
		send_word(make_elem(4096, 4096, 0, 1));
		send_word(make_elem(32767, 1, 32767, 0));
		send_word(make_elem(-32768, 1, -32768, 1));
		send_word(make_elem(32767, 0, 0, 0));
		send_word(make_elem(-32768, 0, -1, 0));
		send_word(make_elem(32767, -1, 32767, 1));
		send_word(make_elem(-32768, -32768, 0, 0));
		send_word(make_elem(32767, -32768, -32768, 1));
		send_word(make_elem(1, -4096, 0, 0));
		send_word(make_elem(-1, -4096, 0, 0));
		send_word(make_elem(12345, -2048, -20000, 1));
		send_word(make_elem(-12345, 32767, 20000, 0));
		send_word(make_elem(-1, -1, -1, 1));
		send_word(make_elem(16'h5555, 16'hAAAA, 16'h5555, 0));
		send_word(make_elem(16'hAAAA, 16'h5555, 16'hAAAA, 1));
		wait_drain();

		// Full-scale alpha: the exp branch term can exceed the gradient.
		write_alpha(16'hFFFF);
		send_word(make_elem(32767, 0, 0, 0));
		send_word(make_elem(-32768, 0, 0, 1));
		send_word(make_elem(32767, -32768, 0, 0));
		send_word(make_elem(-32768, -100, -32768, 1));
		send_random(200);
		wait_drain();

		// Zero alpha: the exp branch adds nothing.
		write_alpha(16'h0000);
		send_word(make_elem(32767, -100, 5, 1));
		send_random(120);
		wait_drain();

		// Receiver holds off while the sender keeps offering, filling the pipeline.
		write_alpha(16'($urandom));
		hold_request = 1'b1;
		src_idle_pct = 0;
		send_random(80);
		src_idle_pct = 25;
		send_random(100);
		wait_drain();

		// A long stretch with no idling on either side.
		write_alpha(16'($urandom));
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		send_random(200);
		wait_drain();
		src_idle_pct  = 25;
		sink_idle_pct = 25;

		write_alpha(16'd4096);
		send_random(200);
		wait_drain();

		write_alpha(16'($urandom_range(1, 8191)));
		send_random(120);
		wait_drain();

		repeat (40) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.flag_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
		end
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
